// ===== design/tiny_byte_machine_executor_core_assert.svh =====
// Assertion macros shared by the executor checker.
`ifndef TINY_BYTE_MACHINE_EXECUTOR_CORE_ASSERT_SVH
`define TINY_BYTE_MACHINE_EXECUTOR_CORE_ASSERT_SVH

// Check cons in the same cycle as ante; expects clk and rst_n in scope.
`define TBM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante; expects clk and rst_n in scope.
`define TBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tbm_pkg.sv =====
// Types, sizes and codes of the tiny byte machine executor.
package tbm_pkg;

  localparam int REG_COUNT   = 4;
  localparam int MEM_COUNT   = 8;
  localparam int WORD_COUNT  = REG_COUNT + MEM_COUNT;
  localparam int ADDR_W      = $clog2(WORD_COUNT);
  localparam int VALID_DEPTH = 1 << ADDR_W;
  localparam int IDX_W       = 4;
  localparam int WORD_W      = 9;
  localparam int MAG_W       = 8;
  localparam int CNT_W       = $clog2(MAG_W);
  localparam int IMM_W       = 16;
  localparam int ALU_W       = 16;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [IMM_W-1:0]  imm_t;
  typedef logic signed [ALU_W-1:0]  alu_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [MAG_W-1:0]         mag_t;

  localparam word_t EMPTY_WORD = 9'sd128;
  localparam imm_t  IMM_MAX    = 16'sd127;
  localparam imm_t  IMM_MIN    = -16'sd128;
  localparam alu_t  ALU_MAX    = 16'sd127;
  localparam alu_t  ALU_MIN    = -16'sd128;
  localparam addr_t REG0_ADDR  = '0;

  typedef enum logic [3:0] {
    ACT_LOAD  = 4'd0,
    ACT_FETCH = 4'd1,
    ACT_MOVE  = 4'd2,
    ACT_ADD   = 4'd3,
    ACT_SUB   = 4'd4,
    ACT_MULT  = 4'd5,
    ACT_DIV   = 4'd6,
    ACT_MOD   = 4'd7,
    ACT_CMP   = 4'd8
  } action_t;

  // Registers sit at the low addresses of the word store, memory words above them.
  function automatic addr_t operand_addr(logic is_mem, idx_t idx);
    return is_mem ? addr_t'(REG_COUNT + int'(idx)) : addr_t'(idx);
  endfunction

  function automatic logic operand_ok(logic is_mem, idx_t idx);
    return is_mem ? (int'(idx) < MEM_COUNT) : (int'(idx) < REG_COUNT);
  endfunction

  // Magnitude of a stored word; both -128 and the empty marker give 128.
  function automatic mag_t word_mag(word_t v);
    logic [WORD_W-1:0] n;
    n = v[WORD_W-1] ? (~v + 1'b1) : v;
    return n[MAG_W-1:0];
  endfunction

endpackage

// ===== design/tbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tbm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tiny_byte_machine_executor_core.sv =====
// Top level of the tiny byte machine executor: sequencer, shared adder and word store.
//
// Usage:
//   Drive a command on the in_ ports and raise start; it is taken at the rising
//   edge where start is high and busy is low. busy stays high while the command
//   runs. The result beat appears on the out_ ports for exactly one cycle with
//   out_valid high; the receiver cannot hold it off and must take it then.
//   busy is already low in the strobe cycle, so the next command may be taken
//   at the edge that ends it.
// Sequence, from the accepting edge: S_RSRC, S_RDST and S_LATCH, then
//   load, fetch, move, unknown codes: S_DONE
//   add, sub, compare:                S_STEP, S_DONE
//   mult, div, mod:                   S_STEP repeated, S_FIX, S_DONE
//   S_RSRC and S_RDST read the source and destination words through the single
//   read port of the word store; mult, div and mod add eight passes through the
//   shared 16-bit adder (shift-add or restoring divide) and one pass for the sign.
//   The strobe cycle follows S_DONE.
// Reset (rst_n low, synchronous) empties every register and memory word through
//   per-word valid bits at once, clears the flags and drops any pending strobe.
module tiny_byte_machine_executor_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [3:0]    in_action,
  input  logic          in_src_is_mem,
  input  tbm_pkg::idx_t in_src_index,
  input  logic          in_dst_is_mem,
  input  tbm_pkg::idx_t in_dst_index,
  input  tbm_pkg::imm_t in_immediate,
  output logic          out_valid,
  output tbm_pkg::word_t out_result_value,
  output logic          out_command_error,
  output logic          out_zero_out,
  output logic          out_sign_out,
  output logic          out_overflow_out
);
  import tbm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RSRC  = 7'b0000010,
    S_RDST  = 7'b0000100,
    S_LATCH = 7'b0001000,
    S_STEP  = 7'b0010000,
    S_FIX   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Latched command.
  action_t act_r;
  addr_t   src_addr_r, dst_addr_r;
  logic    s_ok_r, d_ok_r, d_mem_r, pair_ok_r;
  imm_t    imm_r;

  // Operands and iteration state.
  word_t            vs_r, vd_r;
  alu_t             acc_r, b_r;
  mag_t             quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;

  // Architectural flags and valid bits of the word store.
  logic                   zero_r, sign_r, ovf_r;
  logic [VALID_DEPTH-1:0] valid_r;
  logic                   rd_valid_r;

  // Result beat.
  logic  out_valid_r, out_err_r;
  word_t out_value_r;

  // Word store port.
  addr_t             raddr;
  logic [WORD_W-1:0] ram_rdata;
  word_t             rd_word;

  // Shared adder.
  alu_t alu_a, alu_b, alu_sum;
  logic alu_sub;
  alu_t rem_shift;
  logic div_ge;

  // Retire decisions.
  logic  wb_we, res_err, zero_nxt, sign_nxt, ovf_nxt;
  addr_t wb_addr;
  word_t wb_data, res_value;
  logic  acc_in_rng, imm_in_rng, any_empty;
  word_t acc_word;

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_result_value  = out_value_r;
  assign out_command_error = out_err_r;
  assign out_zero_out      = zero_r;
  assign out_sign_out      = sign_r;
  assign out_overflow_out  = ovf_r;

  // Read the source word first, then the destination word.
  assign raddr   = (state_r == S_RSRC) ? src_addr_r : dst_addr_r;
  assign rd_word = rd_valid_r ? $signed(ram_rdata) : EMPTY_WORD;

  tbm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WORD_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (wb_we && (state_r == S_DONE)),
    .waddr(wb_addr),
    .wdata(wb_data),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  // Shared adder: a + b, or a - b when alu_sub is set.
  assign alu_sum   = alu_a + (alu_sub ? ~alu_b : alu_b) + alu_t'(alu_sub);
  assign rem_shift = {acc_r[ALU_W-2:0], quo_r[MAG_W-1]};
  assign div_ge    = !alu_sum[ALU_W-1];

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    if (state_r == S_STEP) begin
      unique case (act_r) inside
        ACT_ADD: begin
          alu_a = alu_t'(vs_r);
          alu_b = alu_t'(vd_r);
        end
        ACT_SUB: begin
          alu_a   = alu_t'(vd_r);
          alu_b   = alu_t'(vs_r);
          alu_sub = 1'b1;
        end
        ACT_CMP: begin
          alu_a   = alu_t'(vs_r);
          alu_b   = alu_t'(vd_r);
          alu_sub = 1'b1;
        end
        ACT_MULT: begin
          alu_a = acc_r;
          alu_b = b_r;
        end
        ACT_DIV, ACT_MOD: begin
          alu_a   = rem_shift;
          alu_b   = b_r;
          alu_sub = 1'b1;
        end
        default: begin
          alu_a = '0;
        end
      endcase
    end else if (state_r == S_FIX) begin
      // Negate the magnitude when the signed result is negative.
      alu_b   = (act_r == ACT_DIV) ? alu_t'({1'b0, quo_r}) : acc_r;
      alu_sub = neg_r;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_RSRC;
      S_RSRC:  state_nxt = S_RDST;
      S_RDST:  state_nxt = S_LATCH;
      S_LATCH: begin
        unique case (act_r) inside
          ACT_ADD, ACT_SUB, ACT_CMP, ACT_MULT, ACT_DIV, ACT_MOD: state_nxt = S_STEP;
          default: state_nxt = S_DONE;
        endcase
      end
      S_STEP: begin
        unique case (act_r) inside
          ACT_MULT, ACT_DIV, ACT_MOD: begin
            if (cnt_r == CNT_W'(MAG_W - 1)) state_nxt = S_FIX;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FIX:   state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the command and decode operand validity once at acceptance.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      act_r      <= action_t'(in_action);
      src_addr_r <= operand_addr(in_src_is_mem, in_src_index);
      dst_addr_r <= operand_addr(in_dst_is_mem, in_dst_index);
      s_ok_r     <= operand_ok(in_src_is_mem, in_src_index);
      d_ok_r     <= operand_ok(in_dst_is_mem, in_dst_index);
      d_mem_r    <= in_dst_is_mem;
      pair_ok_r  <= !(in_src_is_mem && in_dst_is_mem)
                    && operand_ok(in_src_is_mem, in_src_index)
                    && operand_ok(in_dst_is_mem, in_dst_index);
      imm_r      <= in_immediate;
    end
  end

  // Operand capture and iterations through the shared adder.
  always_ff @(posedge clk) begin
    rd_valid_r <= valid_r[raddr];
    unique case (state_r)
      S_RDST: begin
        vs_r <= rd_word;
      end
      S_LATCH: begin
        vd_r  <= rd_word;
        acc_r <= '0;
        cnt_r <= '0;
        quo_r <= word_mag(vs_r);
        b_r   <= alu_t'(word_mag(rd_word));
        neg_r <= (act_r == ACT_MOD) ? vs_r[WORD_W-1]
                                    : (vs_r[WORD_W-1] ^ rd_word[WORD_W-1]);
      end
      S_STEP: begin
        cnt_r <= cnt_r + 1'b1;
        unique case (act_r) inside
          ACT_MULT: begin
            // Shift-add: add the shifted multiplicand where the multiplier bit is set.
            if (quo_r[0]) acc_r <= alu_sum;
            quo_r <= quo_r >> 1;
            b_r   <= b_r << 1;
          end
          ACT_DIV, ACT_MOD: begin
            // Restoring step: keep the difference when it does not go negative.
            acc_r <= div_ge ? alu_sum : rem_shift;
            quo_r <= {quo_r[MAG_W-2:0], div_ge};
          end
          default: begin
            acc_r <= alu_sum;
          end
        endcase
      end
      S_FIX: begin
        acc_r <= alu_sum;
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  // Retire: pick the result, write-back and flag updates for the command.
  assign acc_in_rng = (acc_r >= ALU_MIN) && (acc_r <= ALU_MAX);
  assign imm_in_rng = (imm_r >= IMM_MIN) && (imm_r <= IMM_MAX);
  assign any_empty  = (vs_r == EMPTY_WORD) || (vd_r == EMPTY_WORD);
  assign acc_word   = $signed(acc_r[WORD_W-1:0]);

  always_comb begin
    wb_we     = 1'b0;
    wb_addr   = REG0_ADDR;
    wb_data   = EMPTY_WORD;
    res_value = EMPTY_WORD;
    res_err   = 1'b0;
    zero_nxt  = zero_r;
    sign_nxt  = sign_r;
    ovf_nxt   = ovf_r;
    unique case (act_r) inside
      ACT_LOAD: begin
        if (!imm_in_rng) begin
          ovf_nxt = 1'b1;
        end else begin
          ovf_nxt = 1'b0;
          if (d_mem_r && d_ok_r) begin
            wb_we     = 1'b1;
            wb_addr   = dst_addr_r;
            wb_data   = $signed(imm_r[WORD_W-1:0]);
            res_value = $signed(imm_r[WORD_W-1:0]);
          end else begin
            res_err = 1'b1;
          end
        end
      end
      ACT_FETCH: begin
        if (s_ok_r) res_value = vs_r;
        else res_err = 1'b1;
      end
      ACT_MOVE: begin
        if (pair_ok_r) begin
          wb_we     = 1'b1;
          wb_addr   = dst_addr_r;
          wb_data   = vs_r;
          res_value = vs_r;
        end else begin
          res_err = 1'b1;
        end
      end
      ACT_ADD, ACT_SUB, ACT_MULT: begin
        if (!pair_ok_r && act_r == ACT_ADD) begin
          res_err = 1'b1;
        end else if (!pair_ok_r || (act_r == ACT_SUB && any_empty)) begin
          res_err = 1'b1;
          wb_we   = 1'b1;
        end else if (!acc_in_rng) begin
          ovf_nxt = 1'b1;
          wb_we   = 1'b1;
        end else begin
          ovf_nxt   = 1'b0;
          zero_nxt  = (acc_r == '0);
          sign_nxt  = acc_r[ALU_W-1];
          wb_we     = 1'b1;
          wb_data   = acc_word;
          res_value = acc_word;
        end
      end
      ACT_DIV, ACT_MOD: begin
        ovf_nxt = 1'b0;
        wb_we   = 1'b1;
        if (!pair_ok_r || any_empty || vd_r == '0) begin
          res_err = 1'b1;
        end else begin
          // The quotient of -128 by -1 lands on the empty marker as is.
          zero_nxt  = (acc_r == '0);
          sign_nxt  = acc_r[ALU_W-1];
          wb_data   = acc_word;
          res_value = acc_word;
        end
      end
      ACT_CMP: begin
        if (pair_ok_r) begin
          zero_nxt  = (acc_r == '0);
          sign_nxt  = !acc_r[ALU_W-1] && (acc_r != '0);
          res_value = '0;
        end else begin
          res_err = 1'b1;
        end
      end
      default: begin
        res_err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r      <= 1'b0;
      sign_r      <= 1'b0;
      ovf_r       <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_DONE);
      if (state_r == S_DONE) begin
        zero_r <= zero_nxt;
        sign_r <= sign_nxt;
        ovf_r  <= ovf_nxt;
        if (wb_we) valid_r[wb_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_value_r <= res_value;
      out_err_r   <= res_err;
    end
  end

endmodule

// ===== design/tbm_checker.sv =====
// Port-level checker for the executor core, bound to the top level.
`include "tiny_byte_machine_executor_core_assert.svh"

module tbm_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input tbm_pkg::word_t out_result_value,
  input logic           out_command_error
);

  `TBM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
  `TBM_ASSERT_SAME(a_strobe_end, out_valid, $past(busy) && !busy, "strobe not at end of a command")
  `TBM_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `TBM_ASSERT_SAME(a_error_empty, out_valid && out_command_error, out_result_value == 9'sd128, "error result without empty marker")

endmodule

bind tiny_byte_machine_executor_core tbm_checker u_tbm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_result_value (out_result_value),
  .out_command_error(out_command_error)
);

// ===== test/tb_tiny_byte_machine_executor_core.sv =====
// Self-checking testbench for the tiny byte machine executor core.
`timescale 1ns / 100ps

module tb_tiny_byte_machine_executor_core;
  import tbm_pkg::*;

  // Action codes outside the instruction set; the core must flag them.
  localparam logic [3:0] ACT_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] ACT_UNKNOWN_HI = 4'd15;

  // Give up after this many cycles with neither a command nor a result beat.
  localparam int STALL_LIMIT   = 2000;
  // Wait well past the slowest command (mult, div, mod) before the verdict.
  localparam int QUIET_CYCLES  = 30;
  localparam int PRINT_LIMIT   = 100;
  localparam int EMPTY_VALUE   = 128;

  typedef struct {
    logic [3:0] action;
    logic       src_is_mem;
    idx_t       src_index;
    logic       dst_is_mem;
    idx_t       dst_index;
    imm_t       immediate;
  } command_t;

  typedef struct {
    word_t value;
    logic  error;
    logic  zero;
    logic  sign;
    logic  overflow;
  } outcome_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  logic [3:0] in_action = '0;
  logic  in_src_is_mem = 1'b0;
  idx_t  in_src_index = '0;
  logic  in_dst_is_mem = 1'b0;
  idx_t  in_dst_index = '0;
  imm_t  in_immediate = '0;
  logic  out_valid;
  word_t out_result_value;
  logic  out_command_error;
  logic  out_zero_out;
  logic  out_sign_out;
  logic  out_overflow_out;

  // Machine state as the predictor sees it.
  word_t shadow_regs [REG_COUNT];
  word_t shadow_mem  [MEM_COUNT];
  logic  shadow_zero;
  logic  shadow_sign;
  logic  shadow_overflow;

  outcome_t pending_outcomes [$];
  int       mismatches = 0;
  int       beats_seen = 0;
  int       stall_cycles = 0;
  bit       idle_on = 1'b1;

  tiny_byte_machine_executor_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_src_is_mem     (in_src_is_mem),
    .in_src_index      (in_src_index),
    .in_dst_is_mem     (in_dst_is_mem),
    .in_dst_index      (in_dst_index),
    .in_immediate      (in_immediate),
    .out_valid         (out_valid),
    .out_result_value  (out_result_value),
    .out_command_error (out_command_error),
    .out_zero_out      (out_zero_out),
    .out_sign_out      (out_sign_out),
    .out_overflow_out  (out_overflow_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic clear_shadow();
    for (int i = 0; i < REG_COUNT; i++) shadow_regs[i] = EMPTY_WORD;
    for (int i = 0; i < MEM_COUNT; i++) shadow_mem[i] = EMPTY_WORD;
    shadow_zero     = 1'b0;
    shadow_sign     = 1'b0;
    shadow_overflow = 1'b0;
  endtask

  function automatic bit index_in_bounds(logic is_mem, idx_t idx);
    return is_mem ? (int'(idx) < MEM_COUNT) : (int'(idx) < REG_COUNT);
  endfunction

  function automatic int shadow_word(logic is_mem, idx_t idx);
    return is_mem ? int'(shadow_mem[idx]) : int'(shadow_regs[idx]);
  endfunction

  function automatic bit fits_byte(int v);
    return v >= -128 && v <= 127;
  endfunction

  // Apply one command to the shadow machine and return the beat it must produce.
  function automatic outcome_t execute_predicted(command_t c);
    outcome_t o;
    bit       pair_ok;
    int       vs;
    int       vd;
    int       r;
    int       imm;
    o.value = EMPTY_WORD;
    o.error = 1'b0;
    imm     = int'(c.immediate);
    pair_ok = !(c.src_is_mem && c.dst_is_mem) &&
              index_in_bounds(c.src_is_mem, c.src_index) &&
              index_in_bounds(c.dst_is_mem, c.dst_index);
    vs = pair_ok ? shadow_word(c.src_is_mem, c.src_index) : 0;
    vd = pair_ok ? shadow_word(c.dst_is_mem, c.dst_index) : 0;

    case (c.action)
      ACT_LOAD: begin
        if (!fits_byte(imm)) begin
          shadow_overflow = 1'b1;
        end else begin
          shadow_overflow = 1'b0;
          if (c.dst_is_mem && int'(c.dst_index) < MEM_COUNT) begin
            shadow_mem[c.dst_index] = word_t'(imm);
            o.value = word_t'(imm);
          end else begin
            o.error = 1'b1;
          end
        end
      end
      ACT_FETCH: begin
        if (index_in_bounds(c.src_is_mem, c.src_index))
          o.value = word_t'(shadow_word(c.src_is_mem, c.src_index));
        else
          o.error = 1'b1;
      end
      ACT_MOVE: begin
        if (!pair_ok) begin
          o.error = 1'b1;
        end else begin
          if (c.dst_is_mem) shadow_mem[c.dst_index] = word_t'(vs);
          else shadow_regs[c.dst_index] = word_t'(vs);
          o.value = word_t'(vs);
        end
      end
      ACT_ADD, ACT_SUB, ACT_MULT: begin
        if (!pair_ok && c.action == ACT_ADD) begin
          // bad add operands leave everything alone
          o.error = 1'b1;
        end else if (!pair_ok ||
                     (c.action == ACT_SUB && (vs == EMPTY_VALUE || vd == EMPTY_VALUE))) begin
          o.error = 1'b1;
          shadow_regs[0] = EMPTY_WORD;
        end else begin
          // empty words take part in add and mult at face value
          if (c.action == ACT_ADD) r = vs + vd;
          else if (c.action == ACT_SUB) r = vd - vs;
          else r = vs * vd;
          if (!fits_byte(r)) begin
            shadow_overflow = 1'b1;
            shadow_regs[0]  = EMPTY_WORD;
          end else begin
            shadow_overflow = 1'b0;
            shadow_zero     = (r == 0);
            shadow_sign     = (r < 0);
            shadow_regs[0]  = word_t'(r);
            o.value         = word_t'(r);
          end
        end
      end
      ACT_DIV, ACT_MOD: begin
        shadow_overflow = 1'b0;
        if (!pair_ok || vs == EMPTY_VALUE || vd == EMPTY_VALUE || vd == 0) begin
          o.error = 1'b1;
          shadow_regs[0] = EMPTY_WORD;
        end else begin
          // truncating divide; -128 / -1 lands on the empty marker itself
          r = (c.action == ACT_DIV) ? vs / vd : vs % vd;
          shadow_zero    = (r == 0);
          shadow_sign    = (r < 0);
          shadow_regs[0] = word_t'(r);
          o.value        = word_t'(r);
        end
      end
      ACT_CMP: begin
        if (!pair_ok) begin
          o.error = 1'b1;
        end else begin
          shadow_sign = (vs > vd);
          shadow_zero = (vs == vd);
          o.value     = '0;
        end
      end
      default: o.error = 1'b1;
    endcase

    o.zero     = shadow_zero;
    o.sign     = shadow_sign;
    o.overflow = shadow_overflow;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic command_t build_command(logic [3:0] action, bit sm, int si,
                                             bit dm, int di, int imm);
    command_t c;
    c.action     = action;
    c.src_is_mem = sm;
    c.src_index  = idx_t'(si);
    c.dst_is_mem = dm;
    c.dst_index  = idx_t'(di);
    c.immediate  = imm_t'(imm);
    return c;
  endfunction

  // Well-formed commands keep operands in range and mostly byte-sized immediates,
  // so the machine fills up and arithmetic sees real values; noise covers the rest.
  function automatic command_t random_command(bit noisy);
    command_t c;
    int       pick;
    if (noisy) begin
      c.action     = 4'($urandom_range(0, 15));
      c.src_is_mem = 1'($urandom_range(0, 1));
      c.src_index  = idx_t'($urandom_range(0, 15));
      c.dst_is_mem = 1'($urandom_range(0, 1));
      c.dst_index  = idx_t'($urandom_range(0, 15));
      c.immediate  = imm_t'($urandom());
      return c;
    end
    pick = $urandom_range(0, 99);
    if (pick < 22) c.action = ACT_LOAD;
    else if (pick < 30) c.action = ACT_FETCH;
    else if (pick < 42) c.action = ACT_MOVE;
    else c.action = 4'($urandom_range(int'(ACT_ADD), int'(ACT_CMP)));
    c.src_is_mem = 1'($urandom_range(0, 1));
    c.src_index  = idx_t'(c.src_is_mem ? $urandom_range(0, MEM_COUNT - 1)
                                       : $urandom_range(0, REG_COUNT - 1));
    if (c.action == ACT_LOAD) c.dst_is_mem = ($urandom_range(0, 9) != 0);
    else if (c.src_is_mem) c.dst_is_mem = 1'b0;
    else c.dst_is_mem = 1'($urandom_range(0, 1));
    c.dst_index  = idx_t'(c.dst_is_mem ? $urandom_range(0, MEM_COUNT - 1)
                                       : $urandom_range(0, REG_COUNT - 1));
    pick = $urandom_range(0, 99);
    if (pick < 55) c.immediate = imm_t'(int'($urandom_range(0, 20)) - 10);
    else if (pick < 85) c.immediate = imm_t'(int'($urandom_range(0, 255)) - 128);
    else if (pick < 93) c.immediate = $urandom_range(0, 1) ? IMM_MAX : IMM_MIN;
    else c.immediate = imm_t'($urandom());
    return c;
  endfunction

  // Send one command beat. start stays high after the accepting edge; the next
  // call either replaces the item or drops start for an idle gap, so start sees
  // one assignment per edge.
  task automatic issue_command(input command_t c);
    if (idle_on && $urandom_range(0, 99) < 24) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 40);
    end
    start         <= 1'b1;
    in_action     <= c.action;
    in_src_is_mem <= c.src_is_mem;
    in_src_index  <= c.src_index;
    in_dst_is_mem <= c.dst_is_mem;
    in_dst_index  <= c.dst_index;
    in_immediate  <= c.immediate;
    // hold until an edge sees start high with busy low
    do @(posedge clk); while (busy !== 1'b0);
    pending_outcomes.push_back(execute_predicted(c));
  endtask

  // Drop start and hold off until every predicted beat has come back.
  task automatic wait_for_outcomes();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Loads at the byte limits, overflowing immediates, bad destinations and fetches.
  task automatic test_load_and_fetch();
    issue_command(build_command(ACT_FETCH, 1'b0, 0, 1'b0, 0, 0));       // empty after reset
    issue_command(build_command(ACT_LOAD, 1'b0, 0, 1'b1, 0, 127));
    issue_command(build_command(ACT_LOAD, 1'b0, 0, 1'b1, MEM_COUNT - 1, -128));
    issue_command(build_command(ACT_LOAD, 1'b1, 15, 1'b1, 2, 128));     // overflow
    issue_command(build_command(ACT_LOAD, 1'b0, 0, 1'b1, 2, -32768));   // overflow
    issue_command(build_command(ACT_LOAD, 1'b0, 0, 1'b1, 2, 32767));    // overflow
    issue_command(build_command(ACT_LOAD, 1'b0, 0, 1'b0, 1, 5));        // register target
    issue_command(build_command(ACT_LOAD, 1'b0, 0, 1'b1, 15, 5));       // index past memory
    issue_command(build_command(ACT_FETCH, 1'b1, MEM_COUNT - 1, 1'b0, 0, 0));
    issue_command(build_command(ACT_FETCH, 1'b1, MEM_COUNT, 1'b0, 0, 0));
  endtask

  // Overflow on add and mult, sub of an empty word, -128 / -1, signed modulo,
  // and divide by zero.
  task automatic test_arith_corners();
    issue_command(build_command(ACT_LOAD, 1'b0, 0, 1'b1, 1, -1));
    issue_command(build_command(ACT_MOVE, 1'b1, MEM_COUNT - 1, 1'b0, 1, 0));  // r1 = -128
    issue_command(build_command(ACT_MOVE, 1'b1, 0, 1'b0, 2, 0));              // r2 = 127
    issue_command(build_command(ACT_ADD, 1'b0, 2, 1'b0, 2, 0));
    issue_command(build_command(ACT_SUB, 1'b0, 0, 1'b0, 1, 0));
    issue_command(build_command(ACT_MULT, 1'b0, 1, 1'b1, 1, 0));
    issue_command(build_command(ACT_DIV, 1'b0, 1, 1'b1, 1, 0));
    issue_command(build_command(ACT_MOD, 1'b0, 1, 1'b1, 0, 0));
    issue_command(build_command(ACT_SUB, 1'b0, 2, 1'b0, 2, 0));               // r0 = 0
    issue_command(build_command(ACT_DIV, 1'b0, 2, 1'b0, 0, 0));
  endtask

  // All three compare outcomes, memory to memory, and unknown action codes.
  task automatic test_compare_and_illegal();
    issue_command(build_command(ACT_CMP, 1'b0, 1, 1'b0, 2, 0));
    issue_command(build_command(ACT_CMP, 1'b0, 2, 1'b0, 1, 0));
    issue_command(build_command(ACT_CMP, 1'b0, 2, 1'b1, 0, 0));
    issue_command(build_command(ACT_CMP, 1'b1, 0, 1'b1, 1, 0));
    issue_command(build_command(ACT_UNKNOWN_LO, 1'b0, 0, 1'b0, 0, 0));
    issue_command(build_command(ACT_UNKNOWN_HI, 1'b1, 15, 1'b1, 15, -1));
  endtask

  // Random programs with random sender gaps; one beat in five is noise.
  task automatic test_random_programs(input int count);
    idle_on = 1'b1;
    for (int i = 0; i < count; i++)
      issue_command(random_command($urandom_range(0, 99) < 20));
  endtask

  // Long stretch with the sender never idling: commands land on the strobe edge.
  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++)
      issue_command(random_command($urandom_range(0, 99) < 20));
    idle_on = 1'b1;
  endtask

  // Pause the sender until the core has answered everything, now and then.
  task automatic test_drain_pauses(input int count);
    for (int i = 0; i < count; i++) begin
      issue_command(random_command($urandom_range(0, 99) < 20));
      if (i == count / 2 || $urandom_range(0, 19) == 0) wait_for_outcomes();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at beat %0d, %s: got %0d, expected %0d", beats_seen, field, got, want);
    mismatches++;
  endtask

  // Compare every result beat with the oldest prediction.
  always @(posedge clk) begin : check_beats
    outcome_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("beat with nothing predicted", int'(out_result_value), 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_result_value !== want.value)
          report_mismatch("result_value", int'(out_result_value), int'(want.value));
        if (out_command_error !== want.error)
          report_mismatch("command_error", int'(out_command_error), int'(want.error));
        if (out_zero_out !== want.zero)
          report_mismatch("zero_out", int'(out_zero_out), int'(want.zero));
        if (out_sign_out !== want.sign)
          report_mismatch("sign_out", int'(out_sign_out), int'(want.sign));
        if (out_overflow_out !== want.overflow)
          report_mismatch("overflow_out", int'(out_overflow_out), int'(want.overflow));
      end
      beats_seen++;
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_shadow();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_and_fetch();
    test_arith_corners();
    test_compare_and_illegal();
    test_random_programs(700);
    test_back_to_back(500);
    test_drain_pauses(300);

    // drain, then let any stray beat show up before the verdict
    wait_for_outcomes();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
